/* src/rv64i_integer_execute_top_defines.svh */
// Assertion macros used by the top-level RTL file.
// Under SYNTHESIS the macros expand to nothing.
`ifndef RV64I_INTEGER_EXECUTE_TOP_DEFINES_SVH
`define RV64I_INTEGER_EXECUTE_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Condition holds at every clock edge out of reset.
`define RVIE_ASSERT_ALWAYS(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("rv64ie assertion failed");

// Same-cycle implication.
`define RVIE_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rv64ie assertion failed");

// Next-cycle implication.
`define RVIE_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rv64ie assertion failed");

`else

`define RVIE_ASSERT_ALWAYS(name, clk, rst_n, expr)
`define RVIE_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define RVIE_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

/* src/rv64ie_pkg.sv */
package rv64ie_pkg;

    localparam int XLEN       = 64;
    localparam int NUM_REGS   = 32;
    localparam int REG_IDX_W  = 5;
    localparam int SHAMT64_W  = 6;
    localparam int SHAMT32_W  = 5;

    typedef logic [XLEN-1:0]      xlen_t;
    typedef logic [REG_IDX_W-1:0] reg_idx_t;

    // major opcodes
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_OP_IMM = 7'h13;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_IMM_32 = 7'h1B;
    localparam logic [6:0] OPC_OP_32  = 7'h3B;

    // funct3
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SRX  = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    // funct7 / funct6
    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;
    localparam logic [5:0] F6_BASE = 6'h00;
    localparam logic [5:0] F6_ALT  = 6'h10;

    typedef struct packed {
        logic     illegal;
        logic     wr;
        reg_idx_t rd;    // zero unless wr
        xlen_t    data;  // zero unless wr
    } exec_result_t;

    function automatic xlen_t sext_word(input logic [31:0] w);
        return {{(XLEN-32){w[31]}}, w};
    endfunction

endpackage

/* src/rv64ie_ram.sv */
module rv64ie_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_a_reg;
    logic [WIDTH-1:0] rd_data_b_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_a_reg <= mem_reg[rd_addr_a];
            rd_data_b_reg <= mem_reg[rd_addr_b];
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

/* src/rv64ie_alu.sv */
module rv64ie_alu (
    input  logic [31:0]              instr,
    input  rv64ie_pkg::xlen_t        pc,
    input  rv64ie_pkg::xlen_t        op_a,
    input  rv64ie_pkg::xlen_t        op_b,
    output rv64ie_pkg::exec_result_t result
);
    import rv64ie_pkg::*;

    logic [6:0]           opc;
    logic [2:0]           f3;
    logic [6:0]           f7;
    logic [5:0]           f6;
    reg_idx_t             rd;
    logic [SHAMT64_W-1:0] shamt64;
    logic [SHAMT32_W-1:0] shamt32;
    logic [SHAMT64_W-1:0] bamt64;
    logic [SHAMT32_W-1:0] bamt32;
    xlen_t                imm_i;
    xlen_t                imm_u;
    xlen_t                res;
    logic [31:0]          w32;
    logic                 ok;
    logic                 wr;

    assign opc     = instr[6:0];
    assign rd      = instr[11:7];
    assign f3      = instr[14:12];
    assign f7      = instr[31:25];
    assign f6      = instr[31:26];
    assign shamt64 = instr[20 +: SHAMT64_W];
    assign shamt32 = instr[20 +: SHAMT32_W];
    assign bamt64  = op_b[SHAMT64_W-1:0];
    assign bamt32  = op_b[SHAMT32_W-1:0];
    assign imm_i   = {{(XLEN-12){instr[31]}}, instr[31:20]};
    assign imm_u   = sext_word({instr[31:12], 12'b0});

    always_comb begin
        res = '0;
        w32 = '0;
        ok  = 1'b1;
        case (opc)
            OPC_LUI:   res = imm_u;
            OPC_AUIPC: res = imm_u + pc;
            OPC_OP_IMM: begin
                case (f3)
                    F3_ADD:  res = op_a + imm_i;
                    F3_SLT:  res = {{(XLEN-1){1'b0}}, $signed(op_a) < $signed(imm_i)};
                    F3_SLTU: res = {{(XLEN-1){1'b0}}, op_a < imm_i};
                    F3_XOR:  res = op_a ^ imm_i;
                    F3_OR:   res = op_a | imm_i;
                    F3_AND:  res = op_a & imm_i;
                    F3_SLL: begin
                        if (f6 == F6_BASE) res = op_a << shamt64;
                        else ok = 1'b0;
                    end
                    F3_SRX: begin
                        if (f6 == F6_BASE)     res = op_a >> shamt64;
                        else if (f6 == F6_ALT) res = $signed(op_a) >>> shamt64;
                        else ok = 1'b0;
                    end
                    default: ok = 1'b0;
                endcase
            end
            OPC_OP: begin
                if (f7 == F7_BASE) begin
                    case (f3)
                        F3_ADD:  res = op_a + op_b;
                        F3_SLL:  res = op_a << bamt64;
                        F3_SLT:  res = {{(XLEN-1){1'b0}}, $signed(op_a) < $signed(op_b)};
                        F3_SLTU: res = {{(XLEN-1){1'b0}}, op_a < op_b};
                        F3_XOR:  res = op_a ^ op_b;
                        F3_SRX:  res = op_a >> bamt64;
                        F3_OR:   res = op_a | op_b;
                        F3_AND:  res = op_a & op_b;
                        default: ok = 1'b0;
                    endcase
                end else if (f7 == F7_ALT && f3 == F3_ADD) begin
                    res = op_a - op_b;
                end else if (f7 == F7_ALT && f3 == F3_SRX) begin
                    res = $signed(op_a) >>> bamt64;
                end else begin
                    ok = 1'b0;
                end
            end
            OPC_IMM_32: begin
                if (f3 == F3_ADD) begin
                    w32 = op_a[31:0] + imm_i[31:0];
                end else if (f3 == F3_SLL && f7 == F7_BASE) begin
                    w32 = op_a[31:0] << shamt32;
                end else if (f3 == F3_SRX && f7 == F7_BASE) begin
                    w32 = op_a[31:0] >> shamt32;
                end else if (f3 == F3_SRX && f7 == F7_ALT) begin
                    w32 = $signed(op_a[31:0]) >>> shamt32;
                end else begin
                    ok = 1'b0;
                end
                res = sext_word(w32);
            end
            OPC_OP_32: begin
                if (f3 == F3_ADD && f7 == F7_BASE) begin
                    w32 = op_a[31:0] + op_b[31:0];
                end else if (f3 == F3_ADD && f7 == F7_ALT) begin
                    w32 = op_a[31:0] - op_b[31:0];
                end else if (f3 == F3_SLL && f7 == F7_BASE) begin
                    w32 = op_a[31:0] << bamt32;
                end else if (f3 == F3_SRX && f7 == F7_BASE) begin
                    w32 = op_a[31:0] >> bamt32;
                end else if (f3 == F3_SRX && f7 == F7_ALT) begin
                    w32 = $signed(op_a[31:0]) >>> bamt32;
                end else begin
                    ok = 1'b0;
                end
                res = sext_word(w32);
            end
            default: ok = 1'b0;
        endcase
    end

    assign wr = ok && (rd != '0);

    assign result.illegal = !ok;
    assign result.wr      = wr;
    assign result.rd      = wr ? rd : '0;
    assign result.data    = wr ? res : '0;

endmodule

/* src/rv64i_integer_execute_top.sv */
//  chan | dir | handshake         | fields
//  -----+-----+-------------------+-------------------------------------------------------------
//  s_   | in  | s_valid, s_ready  | s_instr_word[31:0]
//  m_   | out | m_valid, m_ready  | m_instr_pc, m_reg_write, m_dest_index, m_write_data, m_illegal
//
//  One instruction per cycle while m_ready does not stall the output; each transaction passes
//  through the register-file read stage, then through the ALU into the output register.
//  The RAM read is registered, so a write landing on the accept edge is forwarded.
//  aresetn (synchronous) clears the PC, stage valids and the 32 register valid bits;
//  a register whose valid bit is clear reads as zero, so no clearing pass is needed.
//  m_ready low holds the output; s_ready drops when both stages are full and m_ready is low.

`include "rv64i_integer_execute_top_defines.svh"

module rv64i_integer_execute_top (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_valid,
    output logic              s_ready,
    input  logic [31:0]       s_instr_word,

    output logic              m_valid,
    input  logic              m_ready,
    output rv64ie_pkg::xlen_t m_instr_pc,
    output logic              m_reg_write,
    output logic [4:0]        m_dest_index,
    output rv64ie_pkg::xlen_t m_write_data,
    output logic              m_illegal
);
    import rv64ie_pkg::*;

    // ---------------------------------------------------------------------------------
    // Handshake / stage control
    // ---------------------------------------------------------------------------------
    logic s_accept;
    logic s1_advance;    // read stage hands its instruction to the output register
    logic rf_write;      // register-file write happens on this edge

    logic s1_valid_reg, s1_valid_next;
    logic m_valid_reg;

    // Fetch PC. Advances by 4 per accepted transaction, wrapping mod 2^64.
    xlen_t pc_reg;

    // Read stage payload
    logic [31:0] s1_instr_reg;
    xlen_t       s1_pc_reg;

    // Operand source for the read stage: forwarded, from RAM, or zero (never written)
    logic  fwd_a_reg, fwd_b_reg;
    logic  vld_a_reg, vld_b_reg;
    xlen_t fwd_data_reg;

    // One valid bit per architectural register; bit 0 is never set, so x0 reads zero
    logic [NUM_REGS-1:0] rf_valid_reg;

    reg_idx_t rs1_idx, rs2_idx;
    xlen_t    ram_a, ram_b;
    xlen_t    op_a, op_b;

    exec_result_t exec;

    // Output register
    xlen_t    m_pc_reg;
    logic     m_wr_reg;
    reg_idx_t m_rd_reg;
    xlen_t    m_data_reg;
    logic     m_illegal_reg;

    assign s1_advance = !m_valid_reg || m_ready;
    assign s_ready    = !s1_valid_reg || s1_advance;
    assign s_accept   = s_valid && s_ready;
    assign rf_write   = s1_valid_reg && s1_advance && exec.wr;

    assign rs1_idx = s_instr_word[19:15];
    assign rs2_idx = s_instr_word[24:20];

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_advance) begin
            s1_valid_next = 1'b0;
        end
    end

    // ---------------------------------------------------------------------------------
    // Register file: 32 x 64 RAM, written by the instruction leaving the read stage,
    // read at rs1/rs2 of the incoming transaction.
    // ---------------------------------------------------------------------------------
    rv64ie_ram #(
        .WIDTH (XLEN),
        .DEPTH (NUM_REGS)
    ) u_regfile (
        .clk       (aclk),
        .wr_en     (rf_write),
        .wr_addr   (exec.rd),
        .wr_data   (exec.data),
        .rd_en     (s_accept),
        .rd_addr_a (rs1_idx),
        .rd_addr_b (rs2_idx),
        .rd_data_a (ram_a),
        .rd_data_b (ram_b)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            pc_reg       <= '0;
            rf_valid_reg <= '0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            if (s_accept) begin
                pc_reg <= pc_reg + XLEN'(4);
            end
            if (rf_write) begin
                rf_valid_reg[exec.rd] <= 1'b1;
            end
            if (s1_advance) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Read stage capture. A write on this same edge is not visible in the RAM read,
    // so the write data is caught here instead.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_instr_reg <= s_instr_word;
            s1_pc_reg    <= pc_reg;
            fwd_a_reg    <= rf_write && (exec.rd == rs1_idx);
            fwd_b_reg    <= rf_write && (exec.rd == rs2_idx);
            vld_a_reg    <= rf_valid_reg[rs1_idx];
            vld_b_reg    <= rf_valid_reg[rs2_idx];
            fwd_data_reg <= exec.data;
        end
    end

    assign op_a = fwd_a_reg ? fwd_data_reg : (vld_a_reg ? ram_a : '0);
    assign op_b = fwd_b_reg ? fwd_data_reg : (vld_b_reg ? ram_b : '0);

    // ---------------------------------------------------------------------------------
    // Decode and execute
    // ---------------------------------------------------------------------------------
    rv64ie_alu u_alu (
        .instr  (s1_instr_reg),
        .pc     (s1_pc_reg),
        .op_a   (op_a),
        .op_b   (op_b),
        .result (exec)
    );

    always_ff @(posedge aclk) begin
        if (s1_advance && s1_valid_reg) begin
            m_pc_reg      <= s1_pc_reg;
            m_wr_reg      <= exec.wr;
            m_rd_reg      <= exec.rd;
            m_data_reg    <= exec.data;
            m_illegal_reg <= exec.illegal;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_instr_pc   = m_pc_reg;
    assign m_reg_write  = m_wr_reg;
    assign m_dest_index = m_rd_reg;
    assign m_write_data = m_data_reg;
    assign m_illegal    = m_illegal_reg;

    // ---------------------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------------------
    `RVIE_ASSERT_ALWAYS(a_x0_never_valid, aclk, aresetn, !rf_valid_reg[0])
    `RVIE_ASSERT_IMPL(a_write_is_legal, aclk, aresetn, m_valid && m_reg_write,
                      !m_illegal && (m_dest_index != '0))
    `RVIE_ASSERT_IMPL(a_nowrite_zero, aclk, aresetn, m_valid && !m_reg_write,
                      (m_dest_index == '0) && (m_write_data == '0))
    `RVIE_ASSERT_NEXT(a_pc_step, aclk, aresetn, s_accept,
                      pc_reg == $past(pc_reg) + XLEN'(4))
    `RVIE_ASSERT_NEXT(a_stage_holds, aclk, aresetn, s1_valid_reg && !s1_advance,
                      s1_valid_reg && $stable(s1_instr_reg) && $stable(s1_pc_reg))

endmodule

/* verif/rv64i_integer_execute_top_test.sv */
`timescale 1ns / 100ps

module rv64i_integer_execute_top_test;
    import rv64ie_pkg::*;

    // run shape
    localparam int unsigned RANDOM_ITEMS = 950;
    localparam int unsigned HOLD_CYCLES  = 120;  // long receiver hold-off
    localparam int unsigned HOLD_AT      = 300;  // random transaction that triggers it
    localparam int unsigned DRAIN_AT     = 600;  // random transaction after which the sender drains
    localparam int unsigned TAIL_CYCLES  = 8;    // leave some slack after the last result
    localparam int unsigned CYCLE_LIMIT  = 200_000;
    localparam int unsigned REPORT_CAP   = 40;

    // registers used by the directed rows, named by what they hold
    localparam reg_idx_t REG_ZERO    = 5'd0;
    localparam reg_idx_t REG_ONES    = 5'd2;   // -1
    localparam reg_idx_t REG_PCREL   = 5'd4;   // AUIPC result
    localparam reg_idx_t REG_FIRST   = 5'd5;   // first write after reset
    localparam reg_idx_t REG_SHL     = 5'd6;   // sign bit only
    localparam reg_idx_t REG_ONE     = 5'd7;   // 1
    localparam reg_idx_t REG_MASK    = 5'd11;  // XORI result, used as a shift amount
    localparam reg_idx_t REG_SCRATCH = 5'd20;  // results nobody reads back
    localparam reg_idx_t REG_LAST    = 5'd31;  // LUI of all ones

    // encodings outside the supported set
    localparam logic [5:0] F6_BAD = 6'h01;
    localparam logic [6:0] F7_BAD = 7'h01;

    typedef enum logic [1:0] {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_TOGGLE} rx_mode_t;

    // one retired instruction as seen on the m_ channel
    typedef struct packed {
        xlen_t    pc;
        logic     wr;
        reg_idx_t rd;
        xlen_t    data;
        logic     illegal;
    } retire_t;

    typedef struct {
        logic [31:0] word;
        bit          known;    // outcome typed in by hand
        retire_t     outcome;  // pc filled in from the row index
    } stim_row_t;

    logic        aclk;
    logic        aresetn      = 1'b0;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic [31:0] s_instr_word = 32'h0;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    xlen_t       m_instr_pc;
    logic        m_reg_write;
    logic [4:0]  m_dest_index;
    xlen_t       m_write_data;
    logic        m_illegal;

    rv64i_integer_execute_top dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_instr_word (s_instr_word),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_instr_pc   (m_instr_pc),
        .m_reg_write  (m_reg_write),
        .m_dest_index (m_dest_index),
        .m_write_data (m_write_data),
        .m_illegal    (m_illegal)
    );

    // shadow architectural state, advanced once per accepted transaction
    xlen_t       arch_regs [NUM_REGS];
    xlen_t       arch_pc;
    retire_t     pending_retires [$];
    stim_row_t   directed_rows [$];

    int unsigned cycle_count   = 0;
    int unsigned bad_retires   = 0;
    int unsigned retired       = 0;
    int unsigned writes_seen   = 0;
    int unsigned illegal_seen  = 0;
    int unsigned issued        = 0;
    bit          hold_off_req  = 1'b0;  // set by the sender, served by the receiver
    bit          hold_taken    = 1'b0;
    int unsigned rx_hold_left  = 0;
    int unsigned rx_phase_left = 0;
    rx_mode_t    rx_mode       = RX_OPEN;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Execute one word against the shadow state; returns what the block must retire.
    function automatic retire_t execute_instr(input logic [31:0] w);
        retire_t     r;
        logic [6:0]  opc;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [5:0]  f6;
        reg_idx_t    rd;
        reg_idx_t    rs1;
        reg_idx_t    rs2;
        xlen_t       a;
        xlen_t       b;
        xlen_t       imm_i;
        xlen_t       imm_u;
        xlen_t       res;
        logic [31:0] res_w;
        logic        word_op;
        logic        ok;
        logic        wr;

        opc   = w[6:0];
        rd    = w[11:7];
        f3    = w[14:12];
        rs1   = w[19:15];
        rs2   = w[24:20];
        f7    = w[31:25];
        f6    = w[31:26];
        a     = arch_regs[rs1];
        b     = arch_regs[rs2];
        imm_i = {{52{w[31]}}, w[31:20]};
        imm_u = {{32{w[31]}}, w[31:12], 12'h000};
        res     = '0;
        res_w   = '0;
        word_op = 1'b0;
        ok      = 1'b1;

        case (opc)
            OPC_LUI:   res = imm_u;
            OPC_AUIPC: res = imm_u + arch_pc;
            OPC_OP_IMM: begin
                case (f3)
                    F3_ADD:  res = a + imm_i;
                    F3_SLT:  res = {63'd0, $signed(a) < $signed(imm_i)};
                    F3_SLTU: res = {63'd0, a < imm_i};
                    F3_XOR:  res = a ^ imm_i;
                    F3_OR:   res = a | imm_i;
                    F3_AND:  res = a & imm_i;
                    F3_SLL: begin
                        if (f6 == F6_BASE) res = a << w[25:20];
                        else ok = 1'b0;
                    end
                    default: begin
                        // shift right: logical or arithmetic by funct6
                        if (f6 == F6_BASE) res = a >> w[25:20];
                        else if (f6 == F6_ALT) res = $signed(a) >>> w[25:20];
                        else ok = 1'b0;
                    end
                endcase
            end
            OPC_OP: begin
                if (f7 == F7_BASE) begin
                    case (f3)
                        F3_ADD:  res = a + b;
                        F3_SLL:  res = a << b[5:0];
                        F3_SLT:  res = {63'd0, $signed(a) < $signed(b)};
                        F3_SLTU: res = {63'd0, a < b};
                        F3_XOR:  res = a ^ b;
                        F3_SRX:  res = a >> b[5:0];
                        F3_OR:   res = a | b;
                        default: res = a & b;
                    endcase
                end else if (f7 == F7_ALT && f3 == F3_ADD) begin
                    res = a - b;
                end else if (f7 == F7_ALT && f3 == F3_SRX) begin
                    res = $signed(a) >>> b[5:0];
                end else begin
                    ok = 1'b0;
                end
            end
            OPC_IMM_32: begin
                word_op = 1'b1;
                // shift amount is the rs2 field, five bits
                if (f3 == F3_ADD) res_w = a[31:0] + imm_i[31:0];
                else if (f3 == F3_SLL && f7 == F7_BASE) res_w = a[31:0] << rs2;
                else if (f3 == F3_SRX && f7 == F7_BASE) res_w = a[31:0] >> rs2;
                else if (f3 == F3_SRX && f7 == F7_ALT) res_w = $signed(a[31:0]) >>> rs2;
                else ok = 1'b0;
            end
            OPC_OP_32: begin
                word_op = 1'b1;
                if (f3 == F3_ADD && f7 == F7_BASE) res_w = a[31:0] + b[31:0];
                else if (f3 == F3_ADD && f7 == F7_ALT) res_w = a[31:0] - b[31:0];
                else if (f3 == F3_SLL && f7 == F7_BASE) res_w = a[31:0] << b[4:0];
                else if (f3 == F3_SRX && f7 == F7_BASE) res_w = a[31:0] >> b[4:0];
                else if (f3 == F3_SRX && f7 == F7_ALT) res_w = $signed(a[31:0]) >>> b[4:0];
                else ok = 1'b0;
            end
            default: ok = 1'b0;
        endcase

        if (word_op) res = {{32{res_w[31]}}, res_w};

        // x0 target executes but writes nothing and reports zeros
        wr = ok && (rd != REG_ZERO);
        if (wr) arch_regs[rd] = res;

        r.pc      = arch_pc;
        r.wr      = wr;
        r.rd      = wr ? rd : REG_ZERO;
        r.data    = wr ? res : '0;
        r.illegal = !ok;
        arch_pc   = arch_pc + 64'd4;
        return r;
    endfunction

    function automatic logic [31:0] enc_r(input logic [6:0] f7, input reg_idx_t rs2,
                                          input reg_idx_t rs1, input logic [2:0] f3,
                                          input reg_idx_t rd, input logic [6:0] opc);
        return {f7, rs2, rs1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] enc_i(input logic [11:0] imm, input reg_idx_t rs1,
                                          input logic [2:0] f3, input reg_idx_t rd,
                                          input logic [6:0] opc);
        return {imm, rs1, f3, rd, opc};
    endfunction

    // bias toward a few low registers so back-to-back dependencies are common
    function automatic reg_idx_t pick_reg();
        if ($urandom_range(0, 3) == 0) return reg_idx_t'($urandom_range(0, 3));
        return reg_idx_t'($urandom_range(0, 31));
    endfunction

    function automatic logic [11:0] pick_imm12();
        case ($urandom_range(0, 7))
            0:       return 12'h000;
            1:       return 12'h7FF;
            2:       return 12'h800;
            3:       return 12'hFFF;
            default: return 12'($urandom());
        endcase
    endfunction

    // Mostly well-formed words with random content; some pure noise and some
    // supported opcodes carrying arbitrary funct fields.
    function automatic logic [31:0] random_instr();
        logic [31:0] w;
        logic [6:0]  opc;
        logic [2:0]  f3;
        int unsigned pick;

        pick = $urandom_range(0, 99);
        w    = $urandom();
        if (pick < 8) return w;
        case ($urandom_range(0, 9))
            0:       opc = OPC_LUI;
            1:       opc = OPC_AUIPC;
            2, 3, 4: opc = OPC_OP_IMM;
            5, 6:    opc = OPC_OP;
            7:       opc = OPC_IMM_32;
            default: opc = OPC_OP_32;
        endcase
        w[6:0] = opc;
        if (pick < 18) return w;

        w[11:7]  = pick_reg();
        w[19:15] = pick_reg();
        w[24:20] = pick_reg();
        f3       = w[14:12];
        case (opc)
            OPC_OP_IMM: begin
                if (f3 == F3_SLL) w[31:26] = F6_BASE;
                else if (f3 == F3_SRX) w[31:26] = $urandom_range(0, 1) ? F6_ALT : F6_BASE;
                else w[31:20] = pick_imm12();
            end
            OPC_OP: begin
                w[31:25] = ((f3 == F3_ADD || f3 == F3_SRX) && $urandom_range(0, 1))
                           ? F7_ALT : F7_BASE;
            end
            OPC_IMM_32, OPC_OP_32: begin
                case ($urandom_range(0, 2))
                    0:       f3 = F3_ADD;
                    1:       f3 = F3_SLL;
                    default: f3 = F3_SRX;
                endcase
                w[14:12] = f3;
                if (opc == OPC_IMM_32 && f3 == F3_ADD) w[31:20] = pick_imm12();
                else w[31:25] = (f3 != F3_SLL && $urandom_range(0, 1)) ? F7_ALT : F7_BASE;
            end
            default: ;  // LUI / AUIPC: random upper immediate
        endcase
        return w;
    endfunction

    task automatic add_row(input logic [31:0] word);
        stim_row_t row;
        row.word    = word;
        row.known   = 1'b0;
        row.outcome = '0;
        directed_rows.push_back(row);
    endtask

    task automatic add_known(input logic [31:0] word, input logic wr, input reg_idx_t rd,
                             input xlen_t data, input logic illegal);
        stim_row_t row;
        row.word            = word;
        row.known           = 1'b1;
        row.outcome         = '0;
        row.outcome.wr      = wr;
        row.outcome.rd      = rd;
        row.outcome.data    = data;
        row.outcome.illegal = illegal;
        directed_rows.push_back(row);
    endtask

    // Offer one word and hold it until the transaction completes. s_valid is left
    // high so a following call continues the burst without a bubble.
    task automatic issue_instr(input logic [31:0] w, input bit known, input retire_t typed);
        retire_t predicted;
        s_valid      <= 1'b1;
        s_instr_word <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = execute_instr(w);
        pending_retires.push_back(known ? typed : predicted);
        issued++;
    endtask

    task automatic check_field(input string name, input xlen_t want, input xlen_t got);
        if (want !== got) begin
            if (bad_retires < REPORT_CAP)
                $error("result %0d: %s expected 0x%0h, actual 0x%0h", retired, name, want, got);
            bad_retires++;
        end
    endtask

    // result checker: every m_ transaction against the oldest prediction
    always @(posedge aclk) begin
        retire_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_retires.size() == 0) begin
                $error("result with no instruction outstanding, pc 0x%0h", m_instr_pc);
                bad_retires++;
            end else begin
                want = pending_retires.pop_front();
                check_field("instr_pc",   want.pc,      m_instr_pc);
                check_field("reg_write",  want.wr,      m_reg_write);
                check_field("dest_index", want.rd,      m_dest_index);
                check_field("write_data", want.data,    m_write_data);
                check_field("illegal",    want.illegal, m_illegal);
            end
            retired++;
            if (m_reg_write) writes_seen++;
            if (m_illegal) illegal_seen++;
        end
    end

    // Receiver: random phases of open, mostly-ready, sparse and toggling m_ready,
    // plus one long hold-off on request from the sender.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (rx_hold_left != 0) begin
            rx_hold_left--;
            m_ready <= 1'b0;
        end else if (hold_off_req && !hold_taken) begin
            hold_taken   = 1'b1;
            rx_hold_left = HOLD_CYCLES - 1;
            m_ready <= 1'b0;
        end else begin
            if (rx_phase_left == 0) begin
                rx_mode       = rx_mode_t'($urandom_range(0, 3));
                rx_phase_left = $urandom_range(4, 40);
            end
            rx_phase_left--;
            case (rx_mode)
                RX_OPEN:   m_ready <= 1'b1;
                RX_MOSTLY: m_ready <= ($urandom_range(0, 3) != 0);
                RX_SPARSE: m_ready <= ($urandom_range(0, 2) == 0);
                default:   m_ready <= rx_phase_left[0];
            endcase
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_retires.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        retire_t     typed;
        int unsigned n_random;
        int unsigned burst;
        int unsigned gap;
        bit          hold_asked;
        bit          drained;

        hold_asked = 1'b0;
        drained    = 1'b0;
        n_random   = 0;
        foreach (arch_regs[i]) arch_regs[i] = '0;
        arch_pc = '0;

        // Directed rows, walked right after reset so the PC of row i is 4*i.
        // Rows whose outcome is plain are typed in; the rest go through the predictor.
        add_known(enc_r(F7_BASE, REG_ZERO, REG_ZERO, F3_ADD, REG_FIRST, OPC_OP),
                  1'b1, REG_FIRST, '0, 1'b0);                           // regs read zero
        add_known(32'h0000_0000, 1'b0, REG_ZERO, '0, 1'b1);
        add_known(32'hFFFF_FFFF, 1'b0, REG_ZERO, '0, 1'b1);
        add_known({20'hFFFFF, REG_LAST, OPC_LUI},
                  1'b1, REG_LAST, 64'hFFFF_FFFF_FFFF_F000, 1'b0);
        add_known(enc_i(12'hFFF, REG_ZERO, F3_ADD, REG_ONES, OPC_OP_IMM),
                  1'b1, REG_ONES, '1, 1'b0);
        add_known(enc_i(12'h005, REG_ONES, F3_ADD, REG_ZERO, OPC_OP_IMM),
                  1'b0, REG_ZERO, '0, 1'b0);                            // x0 destination
        add_row({20'h80000, REG_PCREL, OPC_AUIPC});
        add_row(enc_i(12'h000, REG_ONES, F3_SLT, REG_SCRATCH, OPC_OP_IMM));
        add_row(enc_i(12'hFFF, REG_PCREL, F3_SLTU, REG_SCRATCH, OPC_OP_IMM));
        add_row(enc_i(12'h555, REG_LAST, F3_XOR, REG_MASK, OPC_OP_IMM));
        add_row(enc_i(12'h800, REG_PCREL, F3_OR, REG_SCRATCH, OPC_OP_IMM));
        add_row(enc_i(12'h7FF, REG_ONES, F3_AND, REG_SCRATCH, OPC_OP_IMM));
        add_row(enc_i({F6_BASE, 6'd63}, REG_ONES, F3_SLL, REG_SHL, OPC_OP_IMM));
        add_row(enc_i({F6_BASE, 6'd63}, REG_ONES, F3_SRX, REG_ONE, OPC_OP_IMM));
        add_row(enc_i({F6_ALT, 6'd63}, REG_LAST, F3_SRX, REG_SCRATCH, OPC_OP_IMM));
        add_known(enc_i({F6_BAD, 6'd1}, REG_ONES, F3_SLL, REG_SCRATCH, OPC_OP_IMM),
                  1'b0, REG_ZERO, '0, 1'b1);
        add_row(enc_r(F7_ALT, REG_ONES, REG_ZERO, F3_ADD, REG_SCRATCH, OPC_OP));
        add_row(enc_r(F7_BASE, REG_ONE, REG_ONES, F3_SLL, REG_SCRATCH, OPC_OP));
        add_row(enc_r(F7_BASE, REG_ZERO, REG_ONES, F3_SLT, REG_SCRATCH, OPC_OP));
        add_row(enc_r(F7_BASE, REG_ONES, REG_ZERO, F3_SLTU, REG_SCRATCH, OPC_OP));
        add_row(enc_r(F7_BASE, REG_PCREL, REG_LAST, F3_XOR, REG_SCRATCH, OPC_OP));
        add_row(enc_r(F7_BASE, REG_MASK, REG_LAST, F3_SRX, REG_SCRATCH, OPC_OP));
        add_row(enc_r(F7_ALT, REG_MASK, REG_LAST, F3_SRX, REG_SCRATCH, OPC_OP));
        add_row(enc_r(F7_BASE, REG_ONE, REG_SHL, F3_OR, REG_SCRATCH, OPC_OP));
        add_row(enc_r(F7_BASE, REG_PCREL, REG_LAST, F3_AND, REG_SCRATCH, OPC_OP));
        add_known(enc_r(F7_BAD, REG_ONES, REG_ONES, F3_ADD, REG_SCRATCH, OPC_OP),
                  1'b0, REG_ZERO, '0, 1'b1);
        // word ops: 32-bit result sign-extended, five-bit shift amounts
        add_row(enc_i(12'h7FF, REG_ONES, F3_ADD, REG_SCRATCH, OPC_IMM_32));
        add_row(enc_r(F7_BASE, 5'd31, REG_ONES, F3_SLL, REG_SCRATCH, OPC_IMM_32));
        add_row(enc_r(F7_BASE, 5'd31, REG_ONES, F3_SRX, REG_SCRATCH, OPC_IMM_32));
        add_row(enc_r(F7_ALT, 5'd31, REG_LAST, F3_SRX, REG_SCRATCH, OPC_IMM_32));
        add_row(enc_r(F7_BASE, REG_ONE, REG_ONES, F3_ADD, REG_SCRATCH, OPC_OP_32));
        add_row(enc_r(F7_ALT, REG_ONES, REG_ZERO, F3_ADD, REG_SCRATCH, OPC_OP_32));
        add_row(enc_r(F7_BASE, REG_ONES, REG_ONE, F3_SLL, REG_SCRATCH, OPC_OP_32));
        add_row(enc_r(F7_BASE, REG_MASK, REG_LAST, F3_SRX, REG_SCRATCH, OPC_OP_32));
        add_row(enc_r(F7_ALT, REG_ONE, REG_LAST, F3_SRX, REG_SCRATCH, OPC_OP_32));
        add_known(enc_i(12'h000, REG_ONES, F3_SLT, REG_SCRATCH, OPC_IMM_32),
                  1'b0, REG_ZERO, '0, 1'b1);
        // PC wrap is out of reach here: the PC only counts up by 4 from reset.

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            typed    = directed_rows[i].outcome;
            typed.pc = xlen_t'(i) * 64'd4;
            issue_instr(directed_rows[i].word, directed_rows[i].known, typed);
        end

        // Random part: bursts of transactions with random gaps between them.
        while (n_random < RANDOM_ITEMS) begin
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                : $urandom_range(1, 16);
            if (n_random >= HOLD_AT && !hold_asked) begin
                // receiver goes quiet while a long burst backs the block up
                hold_asked   = 1'b1;
                hold_off_req = 1'b1;
                burst        = 40;
            end
            for (int unsigned k = 0; k < burst && n_random < RANDOM_ITEMS; k++) begin
                issue_instr(random_instr(), 1'b0, typed);
                n_random++;
            end
            if (n_random >= DRAIN_AT && !drained) begin
                // sender waits until the block has retired everything
                drained = 1'b1;
                s_valid <= 1'b0;
                do @(posedge aclk); while (pending_retires.size() != 0);
            end else begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap != 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end

        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_retires.size() != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d directed and %0d random instructions, %0d results checked",
                 directed_rows.size(), n_random, retired);
        $display("%0d register writes, %0d illegal words, with a receiver hold-off and a drain",
                 writes_seen, illegal_seen);
        if (bad_retires == 0 && pending_retires.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
